[rtl/blst_pkg.sv]
// Shared types, codes and defaults for the bounded sequential list.
package blst_pkg;

  localparam int DEPTH_DEFAULT         = 64;
  localparam int PAYLOAD_WIDTH_DEFAULT = 64;

  localparam int KIND_W    = 4;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 64;
  localparam int POS_W     = 6;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 7;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR     = 4'd0,
    KIND_INS_FRONT = 4'd1,
    KIND_INS_BACK  = 4'd2,
    KIND_INS_AT    = 4'd3,
    KIND_RM_FRONT  = 4'd4,
    KIND_RM_BACK   = 4'd5,
    KIND_RM_AT     = 4'd6,
    KIND_RM_KEY    = 4'd7,
    KIND_FIND_KEY  = 4'd8,
    KIND_READ_AT   = 4'd9
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_NOKEY  = 3'd3,
    ST_BADPOS = 3'd4
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    logic [POS_W-1:0]  position;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

[rtl/bounded_sequential_list_core.sv]
// Top level of the bounded sequential list: stream ports, record store and output register.
//
//   channel  direction  transfer  fields
//   s_*      in         request   tuser: kind; tdata: entry_key, entry_payload, position
//   m_*      out        result    tuser: status; tdata: found_key, found_payload, entry_count
//
// One request at a time. Clear, remove-back, unused kinds and rejected requests go
// straight to the result; read-at reads its record first. An insert or remove shifts
// the records past its slot, one record per cycle. A key search compares from the front
// to a match or the end; a remove by key then shifts like a remove. A held result stalls
// the sequencer in its last cycle, while the output register lets the next request in.
// Reset is synchronous and empties the list; the record memory is not cleared.
module bounded_sequential_list_core #(
  parameter int DEPTH         = blst_pkg::DEPTH_DEFAULT,
  parameter int PAYLOAD_WIDTH = blst_pkg::PAYLOAD_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] entry_key, [95:32] entry_payload, [101:96] position, [103:102] zero
  input  logic [blst_pkg::IN_DATA_W-1:0]    s_tdata,
  // [3:0] kind
  input  logic [blst_pkg::KIND_W-1:0]       s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] found_key, [95:32] found_payload, [102:96] entry_count, [103] zero
  output logic [blst_pkg::OUT_DATA_W-1:0]   m_tdata,
  // [2:0] status
  output logic [blst_pkg::STATUS_W-1:0]     m_tuser
);
  import blst_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int DW = KEY_W + PAYLOAD_WIDTH;

  request_t         req;
  result_t          res;
  result_t          out_r;
  logic             res_valid;
  logic             res_ready;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [DW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [DW-1:0]    ram_rdata;

  assign req.kind     = s_tuser;
  assign req.key      = s_tdata[31:0];
  assign req.payload  = s_tdata[95:32];
  assign req.position = s_tdata[101:96];

  blst_ctrl #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (req),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  blst_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The output register is free once its transfer completes in the same cycle.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        m_tvalid <= 1'b1;
        out_r    <= res;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {1'b0, out_r.count, out_r.payload, out_r.key};
  assign m_tuser = out_r.status;

endmodule

[rtl/blst_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module blst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/blst_ctrl.sv]
// Request sequencer: decodes a request, scans and shifts the record store one entry a cycle.
module blst_ctrl #(
  parameter int DEPTH         = blst_pkg::DEPTH_DEFAULT,
  parameter int PAYLOAD_WIDTH = blst_pkg::PAYLOAD_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  blst_pkg::request_t                    in_req,
  output logic                                  ram_we,
  output logic [$clog2(DEPTH)-1:0]              ram_waddr,
  output logic [blst_pkg::KEY_W+PAYLOAD_WIDTH-1:0] ram_wdata,
  output logic [$clog2(DEPTH)-1:0]              ram_raddr,
  input  logic [blst_pkg::KEY_W+PAYLOAD_WIDTH-1:0] ram_rdata,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output blst_pkg::result_t                     res
);
  import blst_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {IDLE, COPY, SCAN, RDATA, FINISH} state_t;

  state_t                   state;
  request_t                 req_r;
  logic [CW-1:0]            count;
  logic [CW-1:0]            cur;
  logic [CW-1:0]            last;
  logic [CW-1:0]            slot_r;
  logic [CW-1:0]            ra_q;
  logic [AW-1:0]            wa;
  logic                     iss;
  logic                     rd_go;
  logic                     up;
  status_t                  status_r;
  logic [KEY_W-1:0]         fkey_r;
  logic [PAY_W-1:0]         fpay_r;

  logic                     in_ins;
  logic                     in_needs;
  logic                     full;
  logic                     empty;
  logic [31:0]              posw;
  logic [31:0]              cntw;
  logic [CW-1:0]            ins_slot;
  logic [CW-1:0]            rm_slot;
  logic [CW-1:0]            cur_inc;
  logic [CW-1:0]            cur_dec;
  logic                     req_ins;
  logic                     key_match;
  logic [KEY_W-1:0]         rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;

  assign in_ins   = (in_req.kind == KIND_INS_FRONT) || (in_req.kind == KIND_INS_BACK) ||
                    (in_req.kind == KIND_INS_AT);
  assign in_needs = (in_req.kind >= KIND_RM_FRONT) && (in_req.kind <= KIND_READ_AT);
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign posw     = 32'(in_req.position);
  assign cntw     = 32'(count);
  assign ins_slot = (in_req.kind == KIND_INS_FRONT) ? '0 :
                    (in_req.kind == KIND_INS_BACK)  ? count : CW'(in_req.position);
  assign rm_slot  = (in_req.kind == KIND_RM_FRONT) ? '0 : CW'(in_req.position);
  assign cur_inc  = cur + CW'(1);
  assign cur_dec  = cur - CW'(1);
  assign req_ins  = (req_r.kind == KIND_INS_FRONT) || (req_r.kind == KIND_INS_BACK) ||
                    (req_r.kind == KIND_INS_AT);
  assign rd_key    = ram_rdata[KEY_W-1:0];
  assign rd_pay    = ram_rdata[KEY_W+PAYLOAD_WIDTH-1:KEY_W];
  assign key_match = (rd_key == req_r.key);

  assign in_ready  = (state == IDLE);
  assign res_valid = (state == FINISH);
  assign res       = '{status: status_r, key: fkey_r, payload: fpay_r, count: COUNT_W'(count)};

  always_comb begin
    ram_raddr = cur[AW-1:0];
    if (state == IDLE) begin
      ram_raddr = AW'(in_req.position);
    end
    ram_we    = 1'b0;
    ram_waddr = wa;
    ram_wdata = ram_rdata;
    if (state == COPY) begin
      if (rd_go) begin
        ram_we = 1'b1;
      end else if (!iss && req_ins) begin
        // The gap is open: the new record goes into its slot.
        ram_we    = 1'b1;
        ram_waddr = slot_r[AW-1:0];
        ram_wdata = {req_r.payload[PAYLOAD_WIDTH-1:0], req_r.key};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      iss   <= 1'b0;
      rd_go <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            req_r    <= in_req;
            status_r <= ST_OK;
            fkey_r   <= '0;
            fpay_r   <= '0;
            rd_go    <= 1'b0;
            iss      <= 1'b0;
            state    <= FINISH;
            if (in_ins && full) begin
              status_r <= ST_FULL;
            end else if (in_needs && empty) begin
              status_r <= ST_EMPTY;
            end else begin
              case (in_req.kind)
                KIND_CLEAR: begin
                  count <= '0;
                end
                KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
                  if (in_req.kind == KIND_INS_AT && posw > cntw) begin
                    status_r <= ST_BADPOS;
                  end else begin
                    // Records from the top down to the slot move up by one.
                    slot_r <= ins_slot;
                    up     <= 1'b1;
                    cur    <= count - CW'(1);
                    last   <= ins_slot;
                    iss    <= (ins_slot < count);
                    state  <= COPY;
                  end
                end
                KIND_RM_FRONT, KIND_RM_AT: begin
                  if (posw >= cntw && in_req.kind == KIND_RM_AT) begin
                    status_r <= ST_BADPOS;
                  end else begin
                    slot_r <= rm_slot;
                    up     <= 1'b0;
                    cur    <= rm_slot + CW'(1);
                    last   <= count - CW'(1);
                    iss    <= ((rm_slot + CW'(1)) < count);
                    state  <= COPY;
                  end
                end
                KIND_RM_BACK: begin
                  count <= count - CW'(1);
                end
                KIND_RM_KEY, KIND_FIND_KEY: begin
                  cur   <= '0;
                  last  <= count - CW'(1);
                  iss   <= 1'b1;
                  state <= SCAN;
                end
                KIND_READ_AT: begin
                  if (posw >= cntw) begin
                    status_r <= ST_BADPOS;
                  end else begin
                    state <= RDATA;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        COPY: begin
          rd_go <= iss;
          if (iss) begin
            wa <= up ? cur_inc[AW-1:0] : cur_dec[AW-1:0];
            if (cur == last) begin
              iss <= 1'b0;
            end else begin
              cur <= up ? cur_dec : cur_inc;
            end
          end
          if (!iss && !rd_go) begin
            count <= req_ins ? count + CW'(1) : count - CW'(1);
            state <= FINISH;
          end
        end
        SCAN: begin
          rd_go <= iss;
          if (iss) begin
            ra_q <= cur;
            cur  <= cur_inc;
            iss  <= (cur != last);
          end
          // Reads run one ahead of the compare; a match drops the read in flight.
          if (rd_go) begin
            if (key_match) begin
              if (req_r.kind == KIND_FIND_KEY) begin
                fkey_r <= rd_key;
                fpay_r <= PAY_W'(rd_pay);
                state  <= FINISH;
              end else begin
                slot_r <= ra_q;
                up     <= 1'b0;
                cur    <= ra_q + CW'(1);
                last   <= count - CW'(1);
                iss    <= ((ra_q + CW'(1)) < count);
                rd_go  <= 1'b0;
                state  <= COPY;
              end
            end else if (ra_q == last) begin
              status_r <= ST_NOKEY;
              state    <= FINISH;
            end
          end
        end
        RDATA: begin
          fkey_r <= rd_key;
          fpay_r <= PAY_W'(rd_pay);
          state  <= FINISH;
        end
        FINISH: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[bench/tb_bounded_sequential_list_core.sv]
// Self-checking bench for the bounded sequential list core: a shadow copy of the list predicts each result.
module tb_bounded_sequential_list_core;
  import blst_pkg::*;

  localparam int                RANDOM_ITEMS = 1420;
  localparam int                LONG_HOLD    = 300;
  localparam int                HOLD_AFTER   = 400;
  localparam int                DRAIN_CYCLES = 200;
  localparam logic [KIND_W-1:0] KIND_TOP     = '1;

  typedef enum {FILL_UP, DRAIN_DOWN, CHURN} mood_t;

  // Keeps its own copy of the list, works out each result and queues it until the block answers.
  class list_scoreboard;
    logic [KEY_W-1:0] key_slot [DEPTH_DEFAULT];
    logic [PAY_W-1:0] pay_slot [DEPTH_DEFAULT];
    int               used;
    result_t          awaited [$];
    int               errors;
    int               requests;
    int               results;
    int               peak;
    int               status_tally [5];

    function new();
      used     = 0;
      errors   = 0;
      requests = 0;
      results  = 0;
      peak     = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function int locate(logic [KEY_W-1:0] key);
      for (int i = 0; i < used; i++)
        if (key_slot[i] == key) return i;
      return -1;
    endfunction

    function void drop_at(int p);
      for (int i = p; i + 1 < used; i++) begin
        key_slot[i] = key_slot[i + 1];
        pay_slot[i] = pay_slot[i + 1];
      end
      used--;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [PAY_W-1:0] pay, logic [POS_W-1:0] pos);
      result_t r;
      int      slot;
      bit      ins;
      bit      needs_entry;
      r           = '0;
      r.status    = ST_OK;
      ins         = (kind == KIND_INS_FRONT) || (kind == KIND_INS_BACK) || (kind == KIND_INS_AT);
      needs_entry = (kind >= KIND_RM_FRONT) && (kind <= KIND_READ_AT);
      // A full list is reported before any position is looked at.
      if (ins && used == DEPTH_DEFAULT) begin
        r.status = ST_FULL;
      end else if (needs_entry && used == 0) begin
        r.status = ST_EMPTY;
      end else begin
        case (kind)
          KIND_CLEAR: used = 0;
          KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
            slot = (kind == KIND_INS_FRONT) ? 0 : (kind == KIND_INS_BACK) ? used : int'(pos);
            if (slot > used) begin
              r.status = ST_BADPOS;
            end else begin
              for (int i = used; i > slot; i--) begin
                key_slot[i] = key_slot[i - 1];
                pay_slot[i] = pay_slot[i - 1];
              end
              key_slot[slot] = key;
              pay_slot[slot] = pay;
              used++;
            end
          end
          KIND_RM_FRONT: drop_at(0);
          KIND_RM_BACK:  used--;
          KIND_RM_AT: begin
            if (int'(pos) >= used) r.status = ST_BADPOS;
            else drop_at(int'(pos));
          end
          KIND_RM_KEY: begin
            slot = locate(key);
            if (slot < 0) r.status = ST_NOKEY;
            else drop_at(slot);
          end
          KIND_FIND_KEY: begin
            slot = locate(key);
            if (slot < 0) begin
              r.status = ST_NOKEY;
            end else begin
              r.key     = key_slot[slot];
              r.payload = pay_slot[slot];
            end
          end
          KIND_READ_AT: begin
            if (int'(pos) >= used) begin
              r.status = ST_BADPOS;
            end else begin
              r.key     = key_slot[pos];
              r.payload = pay_slot[pos];
            end
          end
          default: ;
        endcase
      end
      r.count = COUNT_W'(used);
      awaited.push_back(r);
      requests++;
      if (used > peak) peak = used;
    endfunction

    function void field_match(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] key,
                               logic [PAY_W-1:0] pay, logic [COUNT_W-1:0] cnt);
      result_t want;
      results++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status %0d count %0d",
                 $time, st, cnt);
        return;
      end
      want = awaited.pop_front();
      status_tally[int'(want.status)]++;
      field_match("status", 64'(want.status), 64'(st));
      field_match("found_key", 64'(want.key), 64'(key));
      field_match("found_payload", want.payload, pay);
      field_match("entry_count", 64'(want.count), 64'(cnt));
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [KIND_W-1:0]     s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  list_scoreboard sb = new();
  bit             calm = 1'b0;
  bit             held_long = 1'b0;

  bounded_sequential_list_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly no gap, sometimes a short one and now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                       input logic [PAY_W-1:0] pay, input logic [POS_W-1:0] pos);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, pos, pay, key};
    do @(posedge clk); while (!s_tready);
    sb.note_request(kind, key, pay, pos);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_request(input mood_t mood);
    int               r;
    int               pick;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  pay;
    logic [POS_W-1:0]  pos;
    r = $urandom_range(0, 99);
    case (mood)
      FILL_UP: begin
        if (r < 70) kind = KIND_W'($urandom_range(KIND_INS_FRONT, KIND_INS_AT));
        else if (r < 95) kind = KIND_W'($urandom_range(KIND_RM_FRONT, KIND_READ_AT));
        else kind = KIND_W'($urandom_range(KIND_CLEAR, KIND_TOP));
      end
      DRAIN_DOWN: begin
        if (r < 60) kind = KIND_W'($urandom_range(KIND_RM_FRONT, KIND_RM_KEY));
        else if (r < 90) kind = KIND_W'($urandom_range(KIND_INS_FRONT, KIND_READ_AT));
        else kind = KIND_W'($urandom_range(KIND_CLEAR, KIND_TOP));
      end
      default: begin
        if (r < 2) kind = KIND_CLEAR;
        else if (r < 95) kind = KIND_W'($urandom_range(KIND_INS_FRONT, KIND_READ_AT));
        else kind = KIND_W'($urandom_range(KIND_READ_AT + 1, KIND_TOP));
      end
    endcase
    // Keys are often taken from the list itself, or from a narrow band so that duplicates occur.
    pick = $urandom_range(0, 99);
    if (pick < 50 && sb.used > 0) key = sb.key_slot[$urandom_range(0, sb.used - 1)];
    else if (pick < 75) key = KEY_W'($urandom_range(0, 7)) - KEY_W'(4);
    else key = $urandom;
    pay = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 75) pos = POS_W'($urandom_range(0, sb.used));
    else pos = POS_W'($urandom_range(0, 63));
    offer(kind, key, pay, pos);
  endtask

  // Stimulus: directed corner cases first, then phases that fill, drain and churn the list.
  initial begin
    int    sent;
    int    run;
    mood_t mood;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    offer(KIND_RM_FRONT, 32'd1, 64'd0, 6'd0);
    offer(KIND_RM_BACK, 32'd1, 64'd0, 6'd0);
    offer(KIND_RM_AT, 32'd1, 64'd0, 6'd0);
    offer(KIND_RM_KEY, 32'd1, 64'd0, 6'd0);
    offer(KIND_FIND_KEY, 32'd1, 64'd0, 6'd0);
    offer(KIND_READ_AT, 32'd1, 64'd0, 6'd0);
    offer(KIND_TOP, '1, '1, '1);
    offer(KIND_INS_AT, 32'd9, 64'd9, 6'd1);
    offer(KIND_INS_FRONT, 32'h8000_0000, 64'd0, 6'd0);
    offer(KIND_INS_BACK, 32'h7fff_ffff, '1, 6'd0);
    offer(KIND_INS_AT, 32'd5, 64'ha5a5_a5a5_a5a5_a5a5, 6'd2);
    offer(KIND_INS_AT, 32'd5, 64'h5a5a_5a5a_5a5a_5a5a, 6'd1);
    offer(KIND_INS_AT, 32'd6, 64'd6, 6'd63);
    offer(KIND_READ_AT, 32'd0, 64'd0, 6'd0);
    offer(KIND_READ_AT, 32'd0, 64'd0, 6'd3);
    offer(KIND_READ_AT, 32'd0, 64'd0, 6'd4);
    offer(KIND_READ_AT, 32'd0, 64'd0, 6'd63);
    offer(KIND_FIND_KEY, 32'd5, 64'd0, 6'd0);
    offer(KIND_FIND_KEY, 32'd6, 64'd0, 6'd0);
    offer(KIND_RM_KEY, 32'd5, 64'd0, 6'd0);
    offer(KIND_RM_KEY, 32'd6, 64'd0, 6'd0);
    offer(KIND_RM_AT, 32'd0, 64'd0, 6'd3);
    offer(KIND_RM_AT, 32'd0, 64'd0, 6'd1);
    offer(KIND_RM_FRONT, 32'd0, 64'd0, 6'd0);
    offer(KIND_RM_BACK, 32'd0, 64'd0, 6'd0);
    offer(KIND_INS_BACK, 32'd3, 64'd3, 6'd0);
    offer(KIND_CLEAR, 32'd0, 64'd0, 6'd0);

    sent = 0;
    mood = FILL_UP;
    run  = 150;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < run && sent < RANDOM_ITEMS; i++) begin
        random_request(mood);
        sent++;
      end
      mood = mood_t'($urandom_range(0, 2));
      run  = $urandom_range(60, 160);
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d results, with the list at most %0d of %0d full.",
             sb.requests, sb.results, sb.peak, DEPTH_DEFAULT);
    $display("Outcomes: %0d ok, %0d full, %0d empty, %0d key missing, %0d bad position.",
             sb.status_tally[ST_OK], sb.status_tally[ST_FULL], sb.status_tally[ST_EMPTY],
             sb.status_tally[ST_NOKEY], sb.status_tally[ST_BADPOS]);
    if (sb.errors == 0) begin
      $display("tb_bounded_sequential_list_core: done, clean");
    end else begin
      $display("tb_bounded_sequential_list_core: done, errors");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so that the block backs up onto its input.
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (!held_long && sb.requests >= HOLD_AFTER) begin
        held_long = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[31:0], m_tdata[95:32], m_tdata[102:96]);
  end

  initial begin
    #4_000_000;
    $display("tb_bounded_sequential_list_core: done, errors");
    $finish;
  end

endmodule
